// ===== design/wsfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// WebSocket frame receiver package: opcodes, result kinds, status codes
// and the default length width. No dependencies.
package wsfr_pkg;

    localparam int unsigned WSFR_LENGTH_BITS = 64;

    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam int unsigned CTRL_MAX_LEN = 125;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_BIN  = 2'd1,
        KIND_PING = 2'd2,
        KIND_PONG = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_CTRL   = 3'd1,
        ST_RSV    = 3'd2,
        ST_CLOSE  = 3'd3,
        ST_OPCODE = 3'd4
    } t_status;

endpackage
`default_nettype wire

// ===== design/wsfr_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte stream channel: valid/ready handshake with one received byte.
// No dependencies.
interface wsfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== design/wsfr_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result channel: valid/ready handshake with a payload byte and its tags.
// Depends on wsfr_pkg for the kind and status types.
interface wsfr_result_if import wsfr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       data_valid;
    t_kind      msg_kind;
    logic       frame_end;
    logic       message_end;
    t_status    status;

    modport source (
        output valid, output data_byte, output data_valid, output msg_kind,
        output frame_end, output message_end, output status, input ready
    );
    modport sink (
        input valid, input data_byte, input data_valid, input msg_kind,
        input frame_end, input message_end, input status, output ready
    );
endinterface
`default_nettype wire

// ===== design/websocket_frame_receiver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// WebSocket frame receiver: header parse, unmasking and error checks.
// The single input register feeds the result register, which holds a result until o_res.ready.
// Throughput: one byte per cycle when o_res is not stalled, set by that input register.
// Reset: synchronous active low; clears the parser, message state and halt flag.
// Depends on wsfr_pkg, wsfr_byte_if and wsfr_result_if.
module websocket_frame_receiver_top
    import wsfr_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = WSFR_LENGTH_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    wsfr_byte_if.sink           i_rx,
    wsfr_result_if.source       o_res
);

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic                     r_final;
    logic [2:0]               r_rsv;
    logic [3:0]               r_op;
    logic                     r_masked, n_masked;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic [3:0]               r_left, n_left;
    logic [31:0]              r_key, n_key;
    logic [1:0]               r_mphase, n_mphase;
    logic                     r_in_msg, n_in_msg;
    logic                     r_msg_kind, n_msg_kind;
    logic                     r_halted, n_halted;

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;

    logic                     r_out_valid;
    logic [7:0]               r_out_data;
    logic                     r_out_dvalid;
    t_kind                    r_out_kind;
    logic                     r_out_fend;
    logic                     r_out_mend;
    t_status                  r_out_status;

    logic                     proc_fire;
    logic                     hdr_done;
    logic                     pay_begin;
    logic                     res_valid;
    logic [7:0]               res_data;
    logic                     res_dvalid;
    t_kind                    res_kind;
    logic                     res_fend;
    logic                     res_mend;
    t_status                  res_status;
    t_kind                    cur_kind;
    logic                     is_ctrl;
    logic                     end_mend;

    assign proc_fire = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || proc_fire;

    assign is_ctrl  = r_op[3];
    assign cur_kind = is_ctrl ? ((r_op == OP_PING) ? KIND_PING : KIND_PONG)
                    : ((r_in_msg ? r_msg_kind : (r_op == OP_BIN)) ? KIND_BIN : KIND_TEXT);
    assign end_mend = !is_ctrl && r_final;

    always_comb begin
        n_phase    = r_phase;
        n_masked   = r_masked;
        n_len      = r_len;
        n_left     = r_left;
        n_key      = r_key;
        n_mphase   = r_mphase;
        n_in_msg   = r_in_msg;
        n_msg_kind = r_msg_kind;
        n_halted   = r_halted;
        hdr_done   = 1'b0;
        pay_begin  = 1'b0;
        res_valid  = 1'b0;
        res_data   = 8'd0;
        res_dvalid = 1'b0;
        res_kind   = KIND_TEXT;
        res_fend   = 1'b0;
        res_mend   = 1'b0;
        res_status = ST_OK;

        if (r_in_valid && !r_halted) begin
            case (r_phase)
                PH_HDR0: begin
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = r_in_byte[7];
                    n_key    = 32'd0;
                    if (r_in_byte[6:0] == LEN_EXT16 || r_in_byte[6:0] == LEN_EXT64) begin
                        n_left  = (r_in_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        n_len   = '0;
                        n_phase = PH_EXTLEN;
                    end else begin
                        n_len    = LENGTH_BITS'(r_in_byte[6:0]);
                        hdr_done = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    n_len  = {r_len[LENGTH_BITS-9:0], r_in_byte};
                    n_left = r_left - 4'd1;
                    if (n_left == 4'd0) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_key    = {r_key[23:0], r_in_byte};
                    n_mphase = r_mphase + 2'd1;
                    if (n_mphase == 2'd0) begin
                        pay_begin = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    case (r_mphase)
                        2'd0:    res_data = r_in_byte ^ r_key[31:24];
                        2'd1:    res_data = r_in_byte ^ r_key[23:16];
                        2'd2:    res_data = r_in_byte ^ r_key[15:8];
                        default: res_data = r_in_byte ^ r_key[7:0];
                    endcase
                    res_valid  = 1'b1;
                    res_dvalid = 1'b1;
                    res_kind   = cur_kind;
                    n_mphase   = r_mphase + 2'd1;
                    n_len      = r_len - LENGTH_BITS'(1);
                    if (r_len == LENGTH_BITS'(1)) begin
                        res_fend = 1'b1;
                        res_mend = end_mend;
                        if (end_mend) begin
                            n_in_msg = 1'b0;
                        end
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            if (hdr_done) begin
                if (is_ctrl && (n_len > LENGTH_BITS'(CTRL_MAX_LEN) || !r_final)) begin
                    res_status = ST_CTRL;
                end else if (r_rsv != 3'd0) begin
                    res_status = ST_RSV;
                end else if (r_op == OP_CLOSE) begin
                    res_status = ST_CLOSE;
                end else if (is_ctrl) begin
                    if (r_op != OP_PING && r_op != OP_PONG) begin
                        res_status = ST_OPCODE;
                    end
                end else if (!r_in_msg) begin
                    if (r_op != OP_TEXT && r_op != OP_BIN) begin
                        res_status = ST_OPCODE;
                    end else begin
                        n_msg_kind = (r_op == OP_BIN);
                        n_in_msg   = 1'b1;
                    end
                end else if (r_op != OP_CONT) begin
                    res_status = ST_OPCODE;
                end

                if (res_status != ST_OK) begin
                    n_halted  = 1'b1;
                    res_valid = 1'b1;
                end else if (n_masked) begin
                    n_mphase = 2'd0;
                    n_phase  = PH_MASK;
                end else begin
                    pay_begin = 1'b1;
                end
            end

            if (pay_begin) begin
                n_mphase = 2'd0;
                if (n_len == '0) begin
                    res_valid = 1'b1;
                    res_kind  = cur_kind;
                    res_fend  = 1'b1;
                    res_mend  = end_mend;
                    if (end_mend) begin
                        n_in_msg = 1'b0;
                    end
                    n_phase = PH_HDR0;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR0;
            r_final      <= 1'b0;
            r_rsv        <= 3'd0;
            r_op         <= OP_CONT;
            r_masked     <= 1'b0;
            r_len        <= '0;
            r_left       <= 4'd0;
            r_key        <= 32'd0;
            r_mphase     <= 2'd0;
            r_in_msg     <= 1'b0;
            r_msg_kind   <= 1'b0;
            r_halted     <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end

            if (proc_fire) begin
                if (r_in_valid && !r_halted && r_phase == PH_HDR0) begin
                    r_final <= r_in_byte[7];
                    r_rsv   <= r_in_byte[6:4];
                    r_op    <= r_in_byte[3:0];
                end
                r_phase     <= n_phase;
                r_masked    <= n_masked;
                r_len       <= n_len;
                r_left      <= n_left;
                r_key       <= n_key;
                r_mphase    <= n_mphase;
                r_in_msg    <= n_in_msg;
                r_msg_kind  <= n_msg_kind;
                r_halted    <= n_halted;
                r_out_valid <= res_valid;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (proc_fire) begin
            r_out_data   <= res_data;
            r_out_dvalid <= res_dvalid;
            r_out_kind   <= res_kind;
            r_out_fend   <= res_fend;
            r_out_mend   <= res_mend;
            r_out_status <= res_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.data_byte   = r_out_data;
    assign o_res.data_valid  = r_out_dvalid;
    assign o_res.msg_kind    = r_out_kind;
    assign o_res.frame_end   = r_out_fend;
    assign o_res.message_end = r_out_mend;
    assign o_res.status      = r_out_status;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_receiver_top: random frame streams
// with a built-in frame parser predicting every result transaction.
// Depends on wsfr_pkg, wsfr_byte_if and wsfr_result_if.
module testbench;
    import wsfr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [3:0] OP_TOP = 4'hF;
    localparam logic [63:0] LEN_KEEP = (WSFR_LENGTH_BITS >= 64) ? {64{1'b1}}
                                     : ((64'd1 << WSFR_LENGTH_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD
    } parse_step_t;

    typedef enum int { FORM_SHORT, FORM_EXT16, FORM_EXT64 } len_form_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        t_kind      msg_kind;
        logic       frame_end;
        logic       message_end;
        t_status    status;
    } ws_result_t;

    typedef struct {
        logic [7:0] value;
        bit         drain_first;
    } rx_item_t;

    logic i_clk;
    logic i_rst_n;

    wsfr_byte_if   rx_if ();
    wsfr_result_if res_if ();

    websocket_frame_receiver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    rx_item_t   rx_pending[$];
    ws_result_t expected_results[$];

    int mismatch_count;
    int bytes_accepted;
    int results_checked;
    int payload_seen;
    int frame_ends_seen;
    int message_ends_seen;
    int cycle_count;
    t_status halt_status;
    logic steady;
    bit   send_now;
    ws_result_t got_res;
    ws_result_t want_res;

    assign steady = (bytes_accepted >= 500) && (bytes_accepted < 800);

    // parser state of the predictor
    parse_step_t rx_phase;
    logic        hdr_fin;
    logic [2:0]  hdr_rsv;
    logic [3:0]  hdr_op;
    logic        hdr_masked;
    logic [63:0] bytes_left;
    logic [3:0]  len_bytes_pending;
    logic [31:0] unmask_key;
    logic [1:0]  key_idx;
    logic        msg_open;
    logic        msg_is_bin;
    logic        stopped;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task automatic push_result(input logic [7:0] d, input logic dv, input t_kind k,
                               input logic fe, input logic me, input t_status st);
        ws_result_t r;
        r.data_byte   = d;
        r.data_valid  = dv;
        r.msg_kind    = k;
        r.frame_end   = fe;
        r.message_end = me;
        r.status      = st;
        expected_results.push_back(r);
    endtask

    task automatic halt_with(input t_status st);
        stopped = 1'b1;
        push_result(8'h00, 1'b0, KIND_TEXT, 1'b0, 1'b0, st);
    endtask

    function automatic t_kind frame_kind();
        if (hdr_op[3])
            return (hdr_op == OP_PING) ? KIND_PING : KIND_PONG;
        return msg_is_bin ? KIND_BIN : KIND_TEXT;
    endfunction

    function automatic logic close_frame();
        logic mend;
        mend = 1'b0;
        if (!hdr_op[3] && hdr_fin) begin
            mend = 1'b1;
            msg_open = 1'b0;
        end
        rx_phase = PH_HDR0;
        return mend;
    endfunction

    task automatic start_payload();
        t_kind k;
        logic  me;
        key_idx = 2'd0;
        if (bytes_left == 64'd0) begin
            k  = frame_kind();
            me = close_frame();
            push_result(8'h00, 1'b0, k, 1'b1, me, ST_OK);
        end else begin
            rx_phase = PH_PAYLOAD;
        end
    endtask

    task automatic header_done();
        logic ctrl;
        ctrl = hdr_op[3];
        if (ctrl && (bytes_left > CTRL_MAX_LEN || !hdr_fin)) begin
            halt_with(ST_CTRL);
        end else if (hdr_rsv != 3'd0) begin
            halt_with(ST_RSV);
        end else if (hdr_op == OP_CLOSE) begin
            halt_with(ST_CLOSE);
        end else if (ctrl && hdr_op != OP_PING && hdr_op != OP_PONG) begin
            halt_with(ST_OPCODE);
        end else if (!ctrl && !msg_open && hdr_op != OP_TEXT && hdr_op != OP_BIN) begin
            halt_with(ST_OPCODE);
        end else if (!ctrl && msg_open && hdr_op != OP_CONT) begin
            halt_with(ST_OPCODE);
        end else begin
            if (!ctrl && !msg_open) begin
                msg_is_bin = (hdr_op == OP_BIN);
                msg_open   = 1'b1;
            end
            if (hdr_masked) begin
                key_idx  = 2'd0;
                rx_phase = PH_MASK;
            end else begin
                start_payload();
            end
        end
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        logic [7:0] d;
        t_kind      k;
        logic       fe;
        logic       me;
        if (stopped)
            return;
        case (rx_phase)
            PH_HDR0: begin
                hdr_fin  = b[7];
                hdr_rsv  = b[6:4];
                hdr_op   = b[3:0];
                rx_phase = PH_HDR1;
            end
            PH_HDR1: begin
                hdr_masked = b[7];
                unmask_key = 32'd0;
                bytes_left = 64'd0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    len_bytes_pending = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    rx_phase = PH_EXTLEN;
                end else begin
                    bytes_left = {57'd0, b[6:0]};
                    header_done();
                end
            end
            PH_EXTLEN: begin
                bytes_left = {bytes_left[55:0], b} & LEN_KEEP;
                len_bytes_pending = len_bytes_pending - 4'd1;
                if (len_bytes_pending == 4'd0)
                    header_done();
            end
            PH_MASK: begin
                unmask_key = {unmask_key[23:0], b};
                key_idx = key_idx + 2'd1;
                if (key_idx == 2'd0)
                    start_payload();
            end
            PH_PAYLOAD: begin
                d  = b ^ 8'(unmask_key >> ((3 - int'(key_idx)) * 8));
                k  = frame_kind();
                fe = 1'b0;
                me = 1'b0;
                key_idx = key_idx + 2'd1;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 64'd0) begin
                    fe = 1'b1;
                    me = close_frame();
                end
                push_result(d, 1'b1, k, fe, me, ST_OK);
            end
            default: rx_phase = PH_HDR0;
        endcase
    endtask

    task automatic queue_rx_byte(input logic [7:0] v, input bit drain);
        rx_item_t it;
        it.value       = v;
        it.drain_first = drain;
        rx_pending.push_back(it);
    endtask

    task automatic queue_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                               input logic masked, input len_form_t form,
                               input logic [63:0] len, input bit drain);
        logic [31:0] key;
        int n;
        queue_rx_byte({fin, rsv, op}, drain);
        case (form)
            FORM_SHORT: queue_rx_byte({masked, len[6:0]}, 1'b0);
            FORM_EXT16: begin
                queue_rx_byte({masked, LEN_EXT16}, 1'b0);
                queue_rx_byte(len[15:8], 1'b0);
                queue_rx_byte(len[7:0], 1'b0);
            end
            default: begin
                queue_rx_byte({masked, LEN_EXT64}, 1'b0);
                for (int i = 7; i >= 0; i--)
                    queue_rx_byte(len[i*8 +: 8], 1'b0);
            end
        endcase
        if (masked) begin
            key = $urandom;
            for (int i = 3; i >= 0; i--)
                queue_rx_byte(key[i*8 +: 8], 1'b0);
        end
        n = (len > 64'd4096) ? 4 : int'(len);
        for (int i = 0; i < n; i++)
            queue_rx_byte(8'($urandom), 1'b0);
    endtask

    function automatic len_form_t length_form(input logic [63:0] len);
        int r;
        if (len > 64'hFFFF)
            return FORM_EXT64;
        if (len > CTRL_MAX_LEN)
            return ($urandom_range(0, 3) == 0) ? FORM_EXT64 : FORM_EXT16;
        r = $urandom_range(0, 9);
        if (r == 8)
            return FORM_EXT16;
        if (r == 9)
            return FORM_EXT64;
        return FORM_SHORT;
    endfunction

    function automatic logic [63:0] data_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 64'd0;
        if (r < 85)
            return 64'($urandom_range(1, 12));
        if (r < 97)
            return 64'($urandom_range(13, CTRL_MAX_LEN));
        return 64'($urandom_range(CTRL_MAX_LEN + 1, 300));
    endfunction

    task automatic queue_control_frame();
        logic [3:0]  op;
        logic [63:0] len;
        int r;
        op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
        r = $urandom_range(0, 99);
        if (r < 20)
            len = 64'd0;
        else if (r < 90)
            len = 64'($urandom_range(1, 8));
        else
            len = 64'($urandom_range(100, CTRL_MAX_LEN));
        queue_frame(1'b1, 3'd0, op, 1'($urandom_range(0, 1)), length_form(len), len, 1'b0);
    endtask

    task automatic queue_data_message();
        logic [3:0]  op;
        logic [63:0] len;
        int frags;
        op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
        frags = $urandom_range(1, 4);
        for (int f = 0; f < frags; f++) begin
            if ($urandom_range(0, 3) == 0)
                queue_control_frame();
            len = data_length();
            queue_frame(f == frags - 1, 3'd0, (f == 0) ? op : OP_CONT,
                        1'($urandom_range(0, 1)), length_form(len), len, 1'b0);
        end
    endtask

    // close the run with one protocol error; the block halts after it
    task automatic queue_halting_frame();
        logic [63:0] len;
        logic        msk;
        len = 64'($urandom_range(0, 6));
        msk = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: begin
                if ($urandom_range(0, 1))
                    len = {1'b1, 31'($urandom), 32'($urandom)};
                else
                    len = 64'($urandom_range(CTRL_MAX_LEN + 1, 400));
                queue_frame(1'b1, 3'd0, OP_PING, msk, length_form(len), len, 1'b1);
            end
            1: queue_frame(1'b0, 3'd0, OP_PONG, msk, FORM_SHORT, len, 1'b1);
            2: queue_frame(1'b1, 3'($urandom_range(1, 7)), OP_TEXT, msk, FORM_SHORT, len, 1'b1);
            3: queue_frame(1'b1, 3'd0, OP_CLOSE, msk, FORM_SHORT, len, 1'b1);
            4: queue_frame(1'b1, 3'd0, 4'($urandom_range(OP_BIN + 1, OP_CLOSE - 1)),
                           msk, FORM_SHORT, len, 1'b1);
            5: queue_frame(1'b1, 3'd0, 4'($urandom_range(OP_PONG + 1, OP_TOP)),
                           msk, FORM_SHORT, len, 1'b1);
            6: queue_frame(1'b1, 3'd0, OP_CONT, msk, FORM_SHORT, len, 1'b1);
            default: begin
                queue_frame(1'b0, 3'd0, OP_TEXT, msk, FORM_SHORT, len, 1'b1);
                queue_frame(1'b1, 3'd0, $urandom_range(0, 1) ? OP_TEXT : OP_BIN,
                            msk, FORM_SHORT, len, 1'b0);
            end
        endcase
        for (int i = 0; i < 12; i++)
            queue_rx_byte(8'($urandom), 1'b0);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'h00;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                predict_rx_byte(rx_if.rx_byte);
                void'(rx_pending.pop_front());
                bytes_accepted++;
            end
            if (!(rx_if.valid && !rx_if.ready)) begin
                send_now = (rx_pending.size() != 0)
                        && (steady || $urandom_range(0, 99) >= 35);
                if (send_now && rx_pending[0].drain_first && expected_results.size() != 0)
                    send_now = 1'b0;
                if (send_now) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= rx_pending[0].value;
                end else begin
                    rx_if.valid   <= 1'b0;
                    rx_if.rx_byte <= 8'($urandom);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got_res.data_byte   = res_if.data_byte;
                got_res.data_valid  = res_if.data_valid;
                got_res.msg_kind    = res_if.msg_kind;
                got_res.frame_end   = res_if.frame_end;
                got_res.message_end = res_if.message_end;
                got_res.status      = res_if.status;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", got_res));
                end else begin
                    want_res = expected_results.pop_front();
                    results_checked++;
                    if (got_res.data_byte !== want_res.data_byte)
                        report_mismatch($sformatf("data_byte %02h, want %02h",
                                        got_res.data_byte, want_res.data_byte));
                    if (got_res.data_valid !== want_res.data_valid)
                        report_mismatch($sformatf("data_valid %b, want %b",
                                        got_res.data_valid, want_res.data_valid));
                    if (got_res.msg_kind !== want_res.msg_kind)
                        report_mismatch($sformatf("msg_kind %0d, want %0d",
                                        got_res.msg_kind, want_res.msg_kind));
                    if (got_res.frame_end !== want_res.frame_end)
                        report_mismatch($sformatf("frame_end %b, want %b",
                                        got_res.frame_end, want_res.frame_end));
                    if (got_res.message_end !== want_res.message_end)
                        report_mismatch($sformatf("message_end %b, want %b",
                                        got_res.message_end, want_res.message_end));
                    if (got_res.status !== want_res.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                        got_res.status, want_res.status));
                    if (want_res.data_valid)
                        payload_seen++;
                    if (want_res.frame_end)
                        frame_ends_seen++;
                    if (want_res.message_end)
                        message_ends_seen++;
                    if (want_res.status != ST_OK)
                        halt_status = want_res.status;
                end
            end
            res_if.ready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = 8'h00;
        res_if.ready      = 1'b0;
        mismatch_count    = 0;
        bytes_accepted    = 0;
        results_checked   = 0;
        payload_seen      = 0;
        frame_ends_seen   = 0;
        message_ends_seen = 0;
        cycle_count       = 0;
        halt_status       = ST_OK;
        rx_phase          = PH_HDR0;
        hdr_fin           = 1'b0;
        hdr_rsv           = 3'd0;
        hdr_op            = OP_CONT;
        hdr_masked        = 1'b0;
        bytes_left        = 64'd0;
        len_bytes_pending = 4'd0;
        unmask_key        = 32'd0;
        key_idx           = 2'd0;
        msg_open          = 1'b0;
        msg_is_bin        = 1'b0;
        stopped           = 1'b0;

        queue_frame(1'b1, 3'd0, OP_TEXT, 1'b0, FORM_SHORT, 64'd0, 1'b0);
        queue_frame(1'b1, 3'd0, OP_BIN, 1'b0, FORM_SHORT, 64'd1, 1'b0);
        queue_frame(1'b0, 3'd0, OP_TEXT, 1'b1, FORM_EXT16, 64'd0, 1'b0);
        queue_frame(1'b1, 3'd0, OP_PING, 1'b1, FORM_SHORT, 64'd2, 1'b0);
        queue_frame(1'b1, 3'd0, OP_PONG, 1'b0, FORM_SHORT, 64'd0, 1'b0);
        queue_frame(1'b0, 3'd0, OP_CONT, 1'b1, FORM_EXT64, 64'd1, 1'b0);
        queue_frame(1'b0, 3'd0, OP_CONT, 1'b0, FORM_SHORT, 64'd0, 1'b0);
        queue_frame(1'b1, 3'd0, OP_CONT, 1'b0, FORM_SHORT, 64'd2, 1'b0);

        // hold until drained, then the largest control payload
        queue_frame(1'b1, 3'd0, OP_PING, 1'b1, FORM_SHORT, 64'(CTRL_MAX_LEN), 1'b1);
        while (rx_pending.size() < 1400) begin
            if ($urandom_range(0, 4) == 0)
                queue_control_frame();
            else
                queue_data_message();
        end
        queue_halting_frame();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d bytes, %0d results: %0d payload bytes, %0d frames, %0d messages",
                 bytes_accepted, results_checked, payload_seen, frame_ends_seen,
                 message_ends_seen);
        $display("stream closed by error status %s", halt_status.name());
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
